// File: hw/rtl/dsc_pkg.sv
`default_nettype none
package dsc_pkg;

  localparam int MAX_BATCH_DEF = 64;
  localparam int CYL_BITS_DEF = 16;

  // cell operations
  typedef logic [1:0] op_t;
  localparam op_t OP_NONE = 2'd0;
  localparam op_t OP_INS = 2'd1;
  localparam op_t OP_MOVE = 2'd2;

  // chain control
  typedef struct packed {
    op_t  op;
    logic rotate;
  } chain_ctl_t;

  typedef struct packed {
    logic [15:0] request_cylinder;
    logic [15:0] request_tag;
    logic        use_cscan;
    logic        last_request;
  } request_t;

  typedef struct packed {
    logic [15:0] served_cylinder;
    logic [15:0] served_tag;
    logic        last_served;
    logic [23:0] batch_travel;
    logic [31:0] total_movement;
    logic [31:0] total_served;
    logic        batch_overflow;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/disk_scan_cscan_scheduler_top.sv
`default_nettype none
// channel   | direction | handshake                 | payload
// request   | in        | start & !busy             | dsc_pkg::request_t
// result    | out       | done, no stall            | dsc_pkg::result_t
// config    | in        | cfg_we                    | cfg_index, cfg_data
//
// a request that is not last is stored in the sorted cell rows. the last one
// closes the batch: the S_CALC state rotates the sorted cell rows to total the
// movement, S_SUM adds the totals, then one result per stored request leaves per
// cycle; busy is high from the last request until the final result.
// synchronous reset empties the row and clears totals and counters.
// results cannot be stalled.
module disk_scan_cscan_scheduler_top #(
  parameter int MAX_BATCH = dsc_pkg::MAX_BATCH_DEF,
  parameter int CYL_BITS = dsc_pkg::CYL_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire dsc_pkg::request_t request,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [16:0]       cfg_data,
  output logic                   done,
  output dsc_pkg::result_t       result
);

  localparam int KW = CYL_BITS + 1;
  localparam int DW = CYL_BITS + 16;
  localparam int CW = $clog2(MAX_BATCH + 1);
  localparam int RW = $clog2(MAX_BATCH);
  localparam int GW = 34;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_SUM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic IDX_MAX = 1'b0;
  localparam logic IDX_HEAD = 1'b1;

  logic [1:0]          state;
  logic [CW-1:0]       count;
  logic [RW-1:0]       rot;
  logic [16:0]         max_cyl;
  logic [CYL_BITS-1:0] head;
  logic                sweeping_up;
  logic [31:0]         movement_total;
  logic [31:0]         served_total;
  logic                dropped;
  logic                mode;
  logic                low_seen;
  logic [31:0]         mv;

  logic [CYL_BITS-1:0] cyl_in;
  logic                upper;
  logic [KW-1:0]       scan_key, cscan_key;
  logic                accept, room;
  dsc_pkg::chain_ctl_t ctl;

  logic                s_v, s_nv, c_v, c_nv;
  logic [KW-1:0]       s_k, c_k;
  logic [DW-1:0]       s_d, c_d;
  logic                e_v, e_nv, e_low;
  logic [DW-1:0]       e_d;
  logic [CYL_BITS-1:0] e_cyl;
  logic [CYL_BITS-1:0] seek_len;
  logic [GW-1:0]       gap;
  logic [31:0]         mv_next;

  assign busy = (state != S_LOAD);
  assign accept = start && !busy;
  assign room = (count < CW'(MAX_BATCH));

  // sort keys, built against the head at load time
  assign cyl_in = CYL_BITS'(request.request_cylinder);
  assign upper = (cyl_in >= head);
  always_comb begin
    if (sweeping_up) scan_key = upper ? {1'b0, cyl_in} : {1'b1, ~cyl_in};
    else scan_key = upper ? {1'b1, cyl_in} : {1'b0, ~cyl_in};
    cscan_key = {!upper, cyl_in};
  end

  // chain control
  always_comb begin
    ctl.op = dsc_pkg::OP_NONE;
    ctl.rotate = 1'b0;
    case (state)
      S_LOAD: if (accept && room) ctl.op = dsc_pkg::OP_INS;
      S_CALC: begin
        ctl.op = dsc_pkg::OP_MOVE;
        ctl.rotate = 1'b1;
      end
      S_EMIT: ctl.op = dsc_pkg::OP_MOVE;
      default: ;
    endcase
  end

  dsc_chain #(.N(MAX_BATCH), .KW(KW), .DW(DW)) u_scan (
    .clk(clk), .rst(rst), .ctl(ctl),
    .new_key(scan_key), .new_data({cyl_in, request.request_tag}),
    .head_valid(s_v), .head_key(s_k), .head_data(s_d), .next_valid(s_nv)
  );

  dsc_chain #(.N(MAX_BATCH), .KW(KW), .DW(DW)) u_cscan (
    .clk(clk), .rst(rst), .ctl(ctl),
    .new_key(cscan_key), .new_data({cyl_in, request.request_tag}),
    .head_valid(c_v), .head_key(c_k), .head_data(c_d), .next_valid(c_nv)
  );

  // entry at the front of the chosen order
  assign e_v = mode ? c_v : s_v;
  assign e_nv = mode ? c_nv : s_nv;
  assign e_d = mode ? c_d : s_d;
  assign e_low = mode ? c_k[KW-1] : s_k[KW-1];
  assign e_cyl = e_d[DW-1:16];
  assign seek_len = (e_cyl >= head) ? e_cyl - head : head - e_cyl;
  assign gap = (GW'(max_cyl) > GW'(head)) ? GW'(max_cyl) - GW'(head) : '0;

  // movement step for the entry passing the front
  always_comb begin
    mv_next = mv;
    if (mode && e_low && !low_seen) mv_next = mv + 32'(gap) + 32'(e_cyl);
    else mv_next = mv + 32'(seek_len);
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      rot <= '0;
      max_cyl <= 17'h10000;
      head <= '0;
      sweeping_up <= 1'b1;
      movement_total <= '0;
      served_total <= '0;
      dropped <= 1'b0;
      mode <= 1'b0;
      low_seen <= 1'b0;
      mv <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_LOAD: begin
          if (cfg_we) begin
            if (cfg_index == IDX_MAX) max_cyl <= cfg_data;
            else if (cfg_index == IDX_HEAD) head <= CYL_BITS'(cfg_data[15:0]);
          end
          if (accept) begin
            if (room) count <= count + 1'b1;
            else dropped <= 1'b1;
            if (request.last_request) begin
              mode <= request.use_cscan;
              state <= S_CALC;
              rot <= '0;
              mv <= '0;
              low_seen <= 1'b0;
            end
          end
        end
        S_CALC: begin
          if (e_v) begin
            mv <= mv_next;
            head <= e_cyl;
            if (mode && e_low) low_seen <= 1'b1;
          end
          rot <= rot + 1'b1;
          if (rot == RW'(MAX_BATCH - 1)) state <= S_SUM;
        end
        S_SUM: begin
          movement_total <= movement_total + mv;
          served_total <= served_total + 32'(count);
          if (!mode) sweeping_up <= !sweeping_up;
          state <= S_EMIT;
        end
        S_EMIT: begin
          done <= 1'b1;
          if (!e_nv) begin
            state <= S_LOAD;
            count <= '0;
            dropped <= 1'b0;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      result.served_cylinder <= 16'(e_cyl);
      result.served_tag <= e_d[15:0];
      result.last_served <= !e_nv;
      result.batch_travel <= e_nv ? 24'd0 : mv[23:0];
      result.total_movement <= movement_total;
      result.total_served <= served_total;
      result.batch_overflow <= dropped;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/dsc_cell.sv
`default_nettype none
module dsc_cell #(
  parameter int KW = 17,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dsc_pkg::op_t  op,
  input  wire logic [KW-1:0] new_key,
  input  wire logic [DW-1:0] new_data,
  input  wire logic          left_ins,
  input  wire logic          left_valid,
  input  wire logic [KW-1:0] left_key,
  input  wire logic [DW-1:0] left_data,
  input  wire logic          right_valid,
  input  wire logic [KW-1:0] right_key,
  input  wire logic [DW-1:0] right_data,
  output logic               valid,
  output logic [KW-1:0]      key,
  output logic [DW-1:0]      data,
  output logic               ins
);

  // new item goes in front of the first larger or empty entry
  assign ins = !valid || (new_key < key);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        dsc_pkg::OP_INS: begin
          if (left_ins) valid <= left_valid;
          else if (ins) valid <= 1'b1;
        end
        dsc_pkg::OP_MOVE: valid <= right_valid;
        default: ;
      endcase
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    case (op)
      dsc_pkg::OP_INS: begin
        if (left_ins) begin
          key <= left_key;
          data <= left_data;
        end else if (ins) begin
          key <= new_key;
          data <= new_data;
        end
      end
      dsc_pkg::OP_MOVE: begin
        key <= right_key;
        data <= right_data;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/dsc_chain.sv
`default_nettype none
module dsc_chain #(
  parameter int N = 64,
  parameter int KW = 17,
  parameter int DW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dsc_pkg::chain_ctl_t ctl,
  input  wire logic [KW-1:0]      new_key,
  input  wire logic [DW-1:0]      new_data,
  output logic                    head_valid,
  output logic [KW-1:0]           head_key,
  output logic [DW-1:0]           head_data,
  output logic                    next_valid
);

  logic [N-1:0]  v;
  logic [N-1:0]  ins;
  logic [KW-1:0] k [N];
  logic [DW-1:0] d [N];

  // row of sorted cells, cell 0 holds the smallest key
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          l_ins, l_v, r_v;
    logic [KW-1:0] l_k, r_k;
    logic [DW-1:0] l_d, r_d;
    if (i == 0) begin : g_first
      assign l_ins = 1'b0;
      assign l_v = 1'b0;
      assign l_k = '0;
      assign l_d = '0;
    end else begin : g_mid
      assign l_ins = ins[i-1];
      assign l_v = v[i-1];
      assign l_k = k[i-1];
      assign l_d = d[i-1];
    end
    if (i == N - 1) begin : g_last
      // rotation closes the ring, a plain shift drains
      assign r_v = ctl.rotate ? v[0] : 1'b0;
      assign r_k = k[0];
      assign r_d = d[0];
    end else begin : g_inner
      assign r_v = v[i+1];
      assign r_k = k[i+1];
      assign r_d = d[i+1];
    end
    dsc_cell #(.KW(KW), .DW(DW)) u_cell (
      .clk(clk), .rst(rst), .op(ctl.op),
      .new_key(new_key), .new_data(new_data),
      .left_ins(l_ins), .left_valid(l_v), .left_key(l_k), .left_data(l_d),
      .right_valid(r_v), .right_key(r_k), .right_data(r_d),
      .valid(v[i]), .key(k[i]), .data(d[i]), .ins(ins[i])
    );
  end

  assign head_valid = v[0];
  assign head_key = k[0];
  assign head_data = d[0];
  assign next_valid = v[1];

endmodule
`default_nettype wire

// File: tb/disk_scan_cscan_scheduler_top_tb.sv
`default_nettype none
module disk_scan_cscan_scheduler_top_tb;

  localparam int BATCH_CAP = dsc_pkg::MAX_BATCH_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 2 * BATCH_CAP + 20;
  localparam int PHASE_ITEMS = 90;
  localparam logic REG_MAX_CYL = 1'b0;
  localparam logic REG_START_HEAD = 1'b1;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dsc_pkg::request_t request;
  logic cfg_we;
  logic cfg_index;
  logic [16:0] cfg_data;
  logic done;
  dsc_pkg::result_t result;

  disk_scan_cscan_scheduler_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  // scheduler state mirror
  logic [16:0] sched_max_cyl;
  logic [15:0] sched_head;
  logic sched_sweep_up;
  logic [31:0] sched_move_total;
  logic [31:0] sched_served_total;
  logic sched_dropped;
  logic [15:0] batch_cyl[$];
  logic [15:0] batch_tag[$];
  dsc_pkg::result_t served_order_q[$];

  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stable sort of index list by cylinder
  function automatic void sort_by_cyl(ref int idx[$], input bit descending);
    int key;
    int j;
    bit move_up;
    for (int i = 1; i < idx.size(); i++) begin
      key = idx[i];
      j = i;
      while (j > 0) begin
        move_up = descending ? (batch_cyl[idx[j-1]] < batch_cyl[key])
                             : (batch_cyl[idx[j-1]] > batch_cyl[key]);
        if (!move_up) break;
        idx[j] = idx[j-1];
        j--;
      end
      idx[j] = key;
    end
  endfunction

  function automatic logic [31:0] seek_to(input logic [15:0] target);
    logic [31:0] span;
    span = (target >= sched_head) ? 32'(target - sched_head) : 32'(sched_head - target);
    sched_head = target;
    return span;
  endfunction

  // schedule one accepted transaction and queue its served order
  task automatic predict_schedule(input dsc_pkg::request_t req);
    int upper[$];
    int lower[$];
    int order[$];
    logic [31:0] move;
    logic [31:0] gap;
    dsc_pkg::result_t r;
    move = 0;
    if (batch_cyl.size() < BATCH_CAP) begin
      batch_cyl.insert(batch_cyl.size(), req.request_cylinder);
      batch_tag.insert(batch_tag.size(), req.request_tag);
    end else begin
      sched_dropped = 1'b1;
    end
    if (!req.last_request) return;
    for (int i = 0; i < batch_cyl.size(); i++) begin
      if (batch_cyl[i] >= sched_head) upper.insert(upper.size(), i);
      else lower.insert(lower.size(), i);
    end
    sort_by_cyl(upper, 1'b0);
    if (!req.use_cscan) begin
      sort_by_cyl(lower, 1'b1);
      if (sched_sweep_up) order = {upper, lower};
      else order = {lower, upper};
      foreach (order[i]) move += seek_to(batch_cyl[order[i]]);
      sched_sweep_up = ~sched_sweep_up;
    end else begin
      sort_by_cyl(lower, 1'b0);
      foreach (upper[i]) move += seek_to(batch_cyl[upper[i]]);
      order = upper;
      if (lower.size() > 0) begin
        gap = (sched_max_cyl > {1'b0, sched_head}) ?
              32'(sched_max_cyl - {1'b0, sched_head}) : 32'd0;
        move += gap + 32'(batch_cyl[lower[0]]);
        sched_head = batch_cyl[lower[0]];
        order.insert(order.size(), lower[0]);
        for (int i = 1; i < lower.size(); i++) begin
          order.insert(order.size(), lower[i]);
          move += seek_to(batch_cyl[lower[i]]);
        end
      end
    end
    sched_move_total += move;
    sched_served_total += 32'(batch_cyl.size());
    foreach (order[i]) begin
      r.served_cylinder = batch_cyl[order[i]];
      r.served_tag = batch_tag[order[i]];
      r.last_served = (i == order.size() - 1);
      r.batch_travel = r.last_served ? move[23:0] : 24'd0;
      r.total_movement = sched_move_total;
      r.total_served = sched_served_total;
      r.batch_overflow = sched_dropped;
      served_order_q.insert(served_order_q.size(), r);
    end
    batch_cyl.delete();
    batch_tag.delete();
    sched_dropped = 1'b0;
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    dsc_pkg::result_t exp_r;
    if (!rst && done) begin
      if (served_order_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        exp_r = served_order_q.pop_front();
        if (result !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch exp %p got %p", exp_r, result);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // start stays high between items of a batch unless idle gaps are drawn, and drops after the last one
  task automatic send_request(input dsc_pkg::request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_schedule(req);
    if (req.last_request) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_CYL) sched_max_cyl = value;
    else begin
      sched_head = value[15:0];
    end
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (served_order_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dsc_pkg::request_t make_req(input logic [15:0] cyl,
                                                 input logic [15:0] tag,
                                                 input logic cscan, input logic last);
    dsc_pkg::request_t r;
    r.request_cylinder = cyl;
    r.request_tag = tag;
    r.use_cscan = cscan;
    r.last_request = last;
    return r;
  endfunction

  // random well formed batch, mostly short, sometimes full or overfull
  task automatic random_batch(output int len);
    int sel;
    logic cscan;
    cscan = 1'($urandom_range(1));
    sel = int'($urandom_range(19));
    if (sel == 0) len = BATCH_CAP + int'($urandom_range(1, 3));
    else if (sel == 1) len = BATCH_CAP;
    else len = int'($urandom_range(1, 8));
    for (int i = 0; i < len; i++)
      send_request(make_req(16'($urandom_range(65535)), 16'($urandom_range(65535)), cscan,
                            i == len - 1));
  endtask

  // directed stimulus table
  typedef struct {
    dsc_pkg::request_t req;
    bit                has_exp;
    dsc_pkg::result_t  exp_r;
  } stim_row_t;

  stim_row_t directed[$];
  dsc_pkg::result_t e0;

  initial begin
    int sent;
    int batch_len;
    timed_out = 0;
    mismatches = 0;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_CYL;
    cfg_data = '0;
    rst = 1'b1;
    send_idle_pct = 0;
    sched_max_cyl = 17'd65536;
    sched_head = 16'd0;
    sched_sweep_up = 1'b1;
    sched_move_total = 0;
    sched_served_total = 0;
    sched_dropped = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single max request after reset: head 0, SCAN up
    e0 = '{served_cylinder: 16'hffff, served_tag: 16'hffff, last_served: 1'b1,
           batch_travel: 24'd65535, total_movement: 32'd65535, total_served: 32'd1,
           batch_overflow: 1'b0};
    directed.insert(directed.size(), stim_row_t'{make_req(16'hffff, 16'hffff, 1'b0, 1'b1), 1, e0});
    // SCAN down sweep, equal cylinders in arrival order
    directed.insert(directed.size(), stim_row_t'{make_req(16'd100, 16'd1, 1'b0, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'd100, 16'd2, 1'b0, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'd0, 16'd3, 1'b0, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'hffff, 16'd4, 1'b0, 1'b1), 0, '0});
    // C-SCAN with flyback
    directed.insert(directed.size(), stim_row_t'{make_req(16'd500, 16'hffff, 1'b1, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'd10, 16'd0, 1'b1, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'd5, 16'h5555, 1'b1, 1'b1), 0, '0});
    // C-SCAN, all below the head
    directed.insert(directed.size(), stim_row_t'{make_req(16'd7, 16'haaaa, 1'b1, 1'b0), 0, '0});
    directed.insert(directed.size(), stim_row_t'{make_req(16'd6, 16'h1234, 1'b1, 1'b1), 0, '0});

    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].has_exp)
        served_order_q[served_order_q.size() - 1] = directed[i].exp_r;
    end
    drain_results();

    // overflow: cap plus one, last item dropped
    for (int i = 0; i <= BATCH_CAP; i++)
      send_request(make_req(16'($urandom_range(65535)), 16'(i), 1'b0, i == BATCH_CAP));
    drain_results();

    // head above max: flyback gap saturates
    write_reg(REG_MAX_CYL, 17'd1);
    write_reg(REG_START_HEAD, 17'hffff);
    send_request(make_req(16'd3, 16'd1, 1'b1, 1'b0));
    send_request(make_req(16'd1, 16'd2, 1'b1, 1'b1));
    drain_results();

    // random phases with changing register settings
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 68 : 0;
      case (phase)
        0: begin
          write_reg(REG_MAX_CYL, 17'd65536);
          write_reg(REG_START_HEAD, 17'd32768);
        end
        1: begin
          write_reg(REG_MAX_CYL, 17'h1ffff);
          write_reg(REG_START_HEAD, 17'd0);
        end
        default: begin
          write_reg(REG_MAX_CYL, 17'($urandom_range(1, 65536)));
          write_reg(REG_START_HEAD, 17'($urandom_range(65535)));
        end
      endcase
      while (sent < (phase + 1) * PHASE_ITEMS) begin
        random_batch(batch_len);
        sent = sent + batch_len;
      end
      drain_results();
    end
    if (mismatches == 0 && served_order_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!timed_out && idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_cell.sv
hw/rtl/dsc_chain.sv
hw/rtl/disk_scan_cscan_scheduler_top.sv
tb/disk_scan_cscan_scheduler_top_tb.sv
